[rtl/core/tdcp_pkg.sv]
// ----------------------------------------------------------------------------
// tdcp_pkg
// shared types, character codes and the power-of-ten table for the
// tagged decimal command parser
// ----------------------------------------------------------------------------
package tdcp_pkg;

  localparam int VAL_W   = 32;  // result value width
  localparam int POW_W   = 24;  // holds 10^7
  localparam int FC_W    = 3;   // fraction digit count
  localparam int TGT_W   = 3;
  localparam int CNT_W   = 5;   // one step per quotient bit

  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_POINT = 8'h2E;  // '.'
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_S     = 8'h53;

  localparam logic [TGT_W-1:0] TGT_P_GAIN   = 3'd0;
  localparam logic [TGT_W-1:0] TGT_I_GAIN   = 3'd1;
  localparam logic [TGT_W-1:0] TGT_D_GAIN   = 3'd2;
  localparam logic [TGT_W-1:0] TGT_ROLL     = 3'd3;
  localparam logic [TGT_W-1:0] TGT_PITCH    = 3'd4;
  localparam logic [TGT_W-1:0] TGT_YAW      = 3'd5;
  localparam logic [TGT_W-1:0] TGT_THROTTLE = 3'd6;
  localparam logic [TGT_W-1:0] TGT_STOP     = 3'd7;

  typedef struct packed {
    logic             term;   // terminator beat of a command
    logic             known;  // tag maps to a target
    logic [TGT_W-1:0] code;
  } lex_cmd_t;

  typedef struct packed {
    logic            start;
    logic            sat;
    logic [FC_W-1:0] frac_count;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             ovf;
    logic [VAL_W-1:0] value;
  } div_rsp_t;

  function automatic logic [POW_W-1:0] pow10(input logic [FC_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  function automatic lex_cmd_t tag_decode(input logic [7:0] t);
    lex_cmd_t c;
    c.term  = 1'b0;
    c.known = 1'b1;
    unique case (t)
      CH_P:    c.code = TGT_P_GAIN;
      CH_I:    c.code = TGT_I_GAIN;
      CH_D:    c.code = TGT_D_GAIN;
      CH_R:    c.code = TGT_ROLL;
      CH_Q:    c.code = TGT_PITCH;
      CH_Y:    c.code = TGT_YAW;
      CH_T:    c.code = TGT_THROTTLE;
      CH_S:    c.code = TGT_STOP;
      default: begin
        c.known = 1'b0;
        c.code  = TGT_P_GAIN;
      end
    endcase
    return c;
  endfunction

endpackage

[rtl/core/tagged_decimal_command_parser.sv]
// ----------------------------------------------------------------------------
// tagged_decimal_command_parser
// serial byte command parser producing a target code and a Q16.16 value
// ----------------------------------------------------------------------------
// A byte is taken whenever in_stall is low. A ';' that closes a command with
// a numeric tag (P I D R Q Y T) starts the shared shift-subtract divider. The
// saturation check is made on the ';' beat itself; then the 32 quotient bits
// are worked out in turn and the result moves into the output register, the
// input stalling meanwhile (an overflowing quotient skips the bit steps; an
// output stall adds to the wait). A ';' after the stop tag S loads a zero
// result, and one after an unknown tag gives nothing. The output register
// holds a finished result while further bytes are taken in.
// ----------------------------------------------------------------------------
module tagged_decimal_command_parser
  import tdcp_pkg::*;
#(
  parameter int MANT_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  parameter int MAX_FRAC   = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [TGT_W-1:0] out_target,
  output logic [VAL_W-1:0] out_value,
  output logic             out_overflow
);

  typedef enum logic [1:0] {T_IDLE, T_DIV, T_STOP} tstate_t;

  tstate_t               state_r, state_nxt;
  logic [TGT_W-1:0]      tgt_r, tgt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [TGT_W-1:0]      out_target_r, out_target_nxt;
  logic [VAL_W-1:0]      out_value_r, out_value_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  beat;
  logic                  out_free;
  logic                  out_load;
  logic                  div_ack;
  lex_cmd_t              cmd;
  logic [MANT_WIDTH-1:0] mant;
  logic                  sat;
  logic [FC_W-1:0]       fc;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign in_stall = (state_r != T_IDLE);
  assign beat     = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  tdcp_lexer #(
    .MANT_WIDTH (MANT_WIDTH),
    .MAX_FRAC   (MAX_FRAC)
  ) u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat_i (beat),
    .byte_i (in_rx_byte),
    .cmd_o  (cmd),
    .mant_o (mant),
    .sat_o  (sat),
    .fc_o   (fc)
  );

  always_comb begin
    div_req.start      = cmd.term && cmd.known && (cmd.code != TGT_STOP);
    div_req.sat        = sat;
    div_req.frac_count = fc;
  end

  tdcp_divider #(
    .MANT_WIDTH (MANT_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (div_req),
    .mant_i (mant),
    .ack_i  (div_ack),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    tgt_nxt        = tgt_r;
    out_target_nxt = out_target_r;
    out_value_nxt  = out_value_r;
    out_ovf_nxt    = out_ovf_r;
    out_load       = 1'b0;
    div_ack        = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (div_req.start) begin
          tgt_nxt   = cmd.code;
          state_nxt = T_DIV;
        end else if (cmd.term && cmd.known) begin
          // stop: number is ignored
          tgt_nxt = cmd.code;
          if (out_free) begin
            out_load       = 1'b1;
            out_target_nxt = cmd.code;
            out_value_nxt  = '0;
            out_ovf_nxt    = 1'b0;
          end else begin
            state_nxt = T_STOP;
          end
        end
      end
      T_DIV: begin
        if (div_rsp.done && out_free) begin
          div_ack        = 1'b1;
          out_load       = 1'b1;
          out_target_nxt = tgt_r;
          out_value_nxt  = div_rsp.value;
          out_ovf_nxt    = div_rsp.ovf;
          state_nxt      = T_IDLE;
        end
      end
      T_STOP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_target_nxt = tgt_r;
          out_value_nxt  = '0;
          out_ovf_nxt    = 1'b0;
          state_nxt      = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      tgt_r        <= '0;
      out_valid_r  <= 1'b0;
      out_target_r <= '0;
      out_value_r  <= '0;
      out_ovf_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tgt_r        <= tgt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_target_r <= out_target_nxt;
      out_value_r  <= out_value_nxt;
      out_ovf_r    <= out_ovf_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_target   = out_target_r;
  assign out_value    = out_value_r;
  assign out_overflow = out_ovf_r;

  a_stall_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> in_stall)
    else $error("byte accepted while divider busy");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_stop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_target_r == TGT_STOP |-> out_value_r == '0 && !out_ovf_r)
    else $error("stop result carries a value");

  a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result overwrote a pending beat");

endmodule

[rtl/core/tdcp_lexer.sv]
// ----------------------------------------------------------------------------
// tdcp_lexer
// per-byte command state: tag capture, saturating decimal mantissa,
// fraction digit count and terminator / abort detection
// ----------------------------------------------------------------------------
module tdcp_lexer
  import tdcp_pkg::*;
#(
  parameter int MANT_WIDTH = 32,
  parameter int MAX_FRAC   = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  beat_i,
  input  logic [7:0]            byte_i,
  output lex_cmd_t              cmd_o,
  output logic [MANT_WIDTH-1:0] mant_o,
  output logic                  sat_o,
  output logic [FC_W-1:0]       fc_o
);

  logic                  in_number_r, in_number_nxt;
  logic [7:0]            tag_r, tag_nxt;
  logic [MANT_WIDTH-1:0] mant_r, mant_nxt;
  logic                  sat_r, sat_nxt;
  logic                  after_point_r, after_point_nxt;
  logic [FC_W-1:0]       fc_r, fc_nxt;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [MANT_WIDTH+3:0] prod;
  logic                  frac_full;
  lex_cmd_t              dec;

  assign is_digit  = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign digit     = 4'(byte_i - CH_0);
  // m*10 + d as two shifts and two adds
  assign prod      = ((MANT_WIDTH+4)'(mant_r) << 3) + ((MANT_WIDTH+4)'(mant_r) << 1)
                   + (MANT_WIDTH+4)'(digit);
  assign frac_full = after_point_r && (fc_r >= FC_W'(MAX_FRAC));
  assign dec       = tag_decode(tag_r);

  always_comb begin
    cmd_o.term  = beat_i && in_number_r && (byte_i == CH_SEMI);
    cmd_o.known = dec.known;
    cmd_o.code  = dec.code;
  end

  always_comb begin
    in_number_nxt   = in_number_r;
    tag_nxt         = tag_r;
    mant_nxt        = mant_r;
    sat_nxt         = sat_r;
    after_point_nxt = after_point_r;
    fc_nxt          = fc_r;
    if (beat_i) begin
      if (!in_number_r) begin
        // any byte at all is taken as the tag
        tag_nxt         = byte_i;
        in_number_nxt   = 1'b1;
        mant_nxt        = '0;
        sat_nxt         = 1'b0;
        after_point_nxt = 1'b0;
        fc_nxt          = '0;
      end else if (byte_i == CH_SEMI || byte_i == CH_SLASH) begin
        in_number_nxt = 1'b0;
      end else if (byte_i == CH_POINT) begin
        after_point_nxt = 1'b1;
        fc_nxt          = '0;
      end else if (is_digit && !frac_full) begin
        if (prod[MANT_WIDTH+3:MANT_WIDTH] != 4'd0) begin
          mant_nxt = '1;
          sat_nxt  = 1'b1;
        end else begin
          mant_nxt = prod[MANT_WIDTH-1:0];
        end
        if (after_point_r) begin
          fc_nxt = fc_r + FC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r   <= 1'b0;
      tag_r         <= '0;
      mant_r        <= '0;
      sat_r         <= 1'b0;
      after_point_r <= 1'b0;
      fc_r          <= '0;
    end else begin
      in_number_r   <= in_number_nxt;
      tag_r         <= tag_nxt;
      mant_r        <= mant_nxt;
      sat_r         <= sat_nxt;
      after_point_r <= after_point_nxt;
      fc_r          <= fc_nxt;
    end
  end

  assign mant_o = mant_r;
  assign sat_o  = sat_r;
  assign fc_o   = fc_r;

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FC_W'(MAX_FRAC))
    else $error("fraction count beyond limit");

  a_fc_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    !after_point_r |-> fc_r == '0)
    else $error("fraction digits counted without a point");

  a_sat_pins_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> mant_r == '1)
    else $error("saturated mantissa not at full scale");

endmodule

[rtl/core/tdcp_divider.sv]
// ----------------------------------------------------------------------------
// tdcp_divider
// shift-subtract unit: mantissa * 2^FRAC_BITS / 10^n, one quotient bit a cycle,
// with a saturation check on entry
// ----------------------------------------------------------------------------
module tdcp_divider
  import tdcp_pkg::*;
#(
  parameter int MANT_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  div_req_t              req_i,
  input  logic [MANT_WIDTH-1:0] mant_i,
  input  logic                  ack_i,
  output div_rsp_t              rsp_o
);

  localparam int NXW = MANT_WIDTH + FRAC_BITS + VAL_W;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_t;

  dstate_t          state_r, state_nxt;
  logic [POW_W-1:0] p_r, p_nxt;
  logic [POW_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic [POW_W-1:0] pw;
  logic [NXW-1:0]   nx;
  logic [NXW-1:0]   lim;
  logic [POW_W:0]   trial;
  logic [POW_W:0]   diff;
  logic             ge;

  assign pw    = pow10(req_i.frac_count);
  assign nx    = NXW'(mant_i) << FRAC_BITS;
  // quotient reaches 2^32 exactly when mantissa >= 10^n * 2^(32-FRAC_BITS)
  assign lim   = NXW'(pw) << (VAL_W - FRAC_BITS);
  assign trial = {rem_r, sh_r[VAL_W-1]};
  assign diff  = trial - {1'b0, p_r};
  assign ge    = (trial >= {1'b0, p_r});

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      D_IDLE: begin
        if (req_i.start) begin
          p_nxt = pw;
          if (NXW'(mant_i) >= lim) begin
            sh_nxt    = '1;
            ovf_nxt   = 1'b1;
            state_nxt = D_DONE;
          end else begin
            rem_nxt   = nx[VAL_W +: POW_W];
            sh_nxt    = nx[VAL_W-1:0];
            ovf_nxt   = req_i.sat;
            cnt_nxt   = CNT_W'(VAL_W - 1);
            state_nxt = D_RUN;
          end
        end
      end
      D_RUN: begin
        // dividend bits shift out the top, quotient bits shift in below
        rem_nxt = ge ? diff[POW_W-1:0] : trial[POW_W-1:0];
        sh_nxt  = {sh_r[VAL_W-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = D_DONE;
        end
      end
      D_DONE: begin
        if (ack_i) begin
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      p_r     <= '0;
      rem_r   <= '0;
      sh_r    <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      rem_r   <= rem_nxt;
      sh_r    <= sh_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    rsp_o.busy  = (state_r != D_IDLE);
    rsp_o.done  = (state_r == D_DONE);
    rsp_o.ovf   = ovf_r;
    rsp_o.value = sh_r;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_RUN |-> rem_r < p_r)
    else $error("partial remainder not below divisor");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_i.start |-> state_r == D_IDLE)
    else $error("divide started while busy");

  a_ack_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    ack_i |-> state_r == D_DONE)
    else $error("result taken before divide finished");

endmodule

[sim/tb_tagged_decimal_command_parser.sv]
// ----------------------------------------------------------------------------
// tb_tagged_decimal_command_parser
// self-checking bench for the serial byte command parser
// ----------------------------------------------------------------------------
// Byte streams go in on the input channel and each result beat is checked
// field by field against a behavioural parser kept inside the bench. A short
// directed part covers odd tag bytes, aborts, fraction handling and
// saturation. A long hold on the result side fills the block up. Random
// commands with random digits, points and noise follow. The sender idles in
// bursts and the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module tb_tagged_decimal_command_parser;
  import tdcp_pkg::*;

  localparam int MANT_W      = 32;
  localparam int FRAC_B      = 16;
  localparam int MAX_FRAC_D  = 6;
  localparam int RAND_BYTES  = 780;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 600;
  localparam logic [63:0] MANT_MAX = (64'd1 << MANT_W) - 64'd1;

  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic [VAL_W-1:0] value;
    logic             overflow;
  } cmd_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_rx_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [TGT_W-1:0] out_target;
  logic [VAL_W-1:0] out_value;
  logic             out_overflow;

  // parser state as the bench sees it
  logic             cmd_open = 1'b0;
  logic [7:0]       cmd_tag = 8'h00;
  logic [63:0]      cmd_mant = '0;
  logic             cmd_mant_sat = 1'b0;
  logic             cmd_after_point = 1'b0;
  logic [FC_W-1:0]  cmd_frac_cnt = '0;

  cmd_result_t due_results[$];

  int errors = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int aborts_seen = 0;
  int overflows_due = 0;
  int stops_due = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_max = 2;
  int hold_asked = 0;

  tagged_decimal_command_parser #(
    .MANT_WIDTH (MANT_W),
    .FRAC_BITS  (FRAC_B),
    .MAX_FRAC   (MAX_FRAC_D)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_target   (out_target),
    .out_value    (out_value),
    .out_overflow (out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 due_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 20)
      $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // updates the bench's parser state with one accepted byte
  task automatic parse_rx_byte(input logic [7:0] b);
    logic [63:0]      digit;
    logic [63:0]      div;
    logic [63:0]      quo;
    logic [63:0]      rem;
    logic             known;
    logic [TGT_W-1:0] code;
    cmd_result_t      res;
    if (!cmd_open) begin
      cmd_tag         = b;
      cmd_open        = 1'b1;
      cmd_mant        = '0;
      cmd_mant_sat    = 1'b0;
      cmd_after_point = 1'b0;
      cmd_frac_cnt    = '0;
    end else if (b == CH_SEMI) begin
      cmd_open = 1'b0;
      known    = 1'b1;
      code     = TGT_P_GAIN;
      case (cmd_tag)
        CH_P:    code = TGT_P_GAIN;
        CH_I:    code = TGT_I_GAIN;
        CH_D:    code = TGT_D_GAIN;
        CH_R:    code = TGT_ROLL;
        CH_Q:    code = TGT_PITCH;
        CH_Y:    code = TGT_YAW;
        CH_T:    code = TGT_THROTTLE;
        CH_S:    code = TGT_STOP;
        default: known = 1'b0;
      endcase
      if (known) begin
        res.target = code;
        if (code == TGT_STOP) begin
          res.value    = '0;
          res.overflow = 1'b0;
          stops_due++;
        end else begin
          div = 64'd1;
          repeat (cmd_frac_cnt) div = div * 64'd10;
          quo = cmd_mant / div;
          rem = cmd_mant % div;
          res.overflow = cmd_mant_sat;
          if ((quo >> (32 - FRAC_B)) != 0) begin
            res.value    = 32'hFFFF_FFFF;
            res.overflow = 1'b1;
          end else begin
            res.value = 32'((quo << FRAC_B) + ((rem << FRAC_B) / div));
          end
          if (res.overflow) overflows_due++;
        end
        due_results.push_back(res);
      end
    end else if (b == CH_SLASH) begin
      cmd_open = 1'b0;
      aborts_seen++;
    end else if (b == CH_POINT) begin
      cmd_after_point = 1'b1;
      cmd_frac_cnt    = '0;
    end else if (b >= CH_0 && b <= CH_9) begin
      digit = 64'(b - CH_0);
      // digits past the fraction limit are dropped
      if (!(cmd_after_point && cmd_frac_cnt >= MAX_FRAC_D)) begin
        if (cmd_mant > (MANT_MAX - digit) / 64'd10) begin
          cmd_mant     = MANT_MAX;
          cmd_mant_sat = 1'b1;
        end else begin
          cmd_mant = cmd_mant * 64'd10 + digit;
        end
        if (cmd_after_point) cmd_frac_cnt = cmd_frac_cnt + FC_W'(1);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_rx_byte(b);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // receiver: long holds on request, otherwise a stall pattern that changes
  initial begin
    int hold_left;
    int hold_taken;
    int mode;
    int mode_left;
    hold_left  = 0;
    hold_taken = 0;
    mode       = 0;
    mode_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(100, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cycle_count % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      begin : check_beat
        cmd_result_t want;
        if (rst_n && out_valid && !out_stall) begin
          if (due_results.size() == 0) begin
            report_mismatch("beat with no result due", 32'({out_target, out_overflow}),
                            32'h0);
          end else begin
            want = due_results.pop_front();
            results_checked++;
            if (out_target !== want.target)
              report_mismatch("target", 32'(out_target), 32'(want.target));
            if (out_value !== want.value)
              report_mismatch("value", out_value, want.value);
            if (out_overflow !== want.overflow)
              report_mismatch("overflow", 32'(out_overflow), 32'(want.overflow));
          end
        end
      end
    end
  end

  task automatic test_odd_tags;
    send_text("S7;");           // stop ignores its number
    send_text(";;");            // terminator taken as tag, unknown
    send_byte(8'hFF);
    send_text("1/");            // abort after an all-ones tag
    send_byte(8'h00);
    send_text("5;");            // unknown tag gives nothing
  endtask

  task automatic test_fractions;
    send_text("P.1234567;");    // seventh fraction digit dropped
    send_text("I5.5.5;");       // second point restarts the count
  endtask

  task automatic test_saturation;
    send_text("R9999999999;");  // mantissa clips
    send_text("Q70000;");       // integer part too big for q16.16
  endtask

  task automatic test_output_backpressure;
    hold_asked++;
    gap_max = 0;
    for (int i = 0; i < 6; i++) begin
      send_byte(CH_P + 8'(i));
      send_byte(CH_0 + 8'($urandom_range(0, 9)));
      send_byte(CH_SEMI);
    end
    wait_for_results;
  endtask

  task automatic send_random_command;
    logic [7:0] known_tags[8];
    logic [7:0] b;
    int         n;
    int         sel;
    known_tags = '{CH_P, CH_I, CH_D, CH_R, CH_Q, CH_Y, CH_T, CH_S};
    if ($urandom_range(0, 9) < 7) send_byte(known_tags[$urandom_range(0, 7)]);
    else                          send_byte(8'($urandom_range(0, 255)));
    sel = $urandom_range(0, 9);
    n   = (sel < 6) ? $urandom_range(0, 4) : (sel < 9) ? $urandom_range(5, 7) :
                                                         $urandom_range(8, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
      send_byte(CH_0 + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) < 6) begin
      repeat ($urandom_range(1, $urandom_range(0, 5) == 0 ? 2 : 1)) begin
        send_byte(CH_POINT);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) send_byte(CH_0 + 8'($urandom_range(0, 9)));
      end
    end
    sel = $urandom_range(0, 19);
    if (sel < 17) begin
      send_byte(CH_SEMI);
    end else if (sel < 19) begin
      send_byte(CH_SLASH);
    end else begin
      // random junk instead of a terminator; unless it is ';' or '/' the next tag lands inside this number
      b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  task automatic test_random_commands;
    int start_bytes;
    int next_pause;
    int next_mode;
    int gap_choice[4];
    gap_choice  = '{0, 0, 3, 12};
    start_bytes = bytes_sent;
    next_pause  = 150;
    next_mode   = 0;
    while (bytes_sent - start_bytes < RAND_BYTES) begin
      if (bytes_sent - start_bytes >= next_mode) begin
        gap_max   = gap_choice[$urandom_range(0, 3)];
        next_mode += 100;
      end
      if (bytes_sent - start_bytes >= next_pause) begin
        wait_for_results;
        if (next_pause == 450) hold_asked++;
        next_pause += 150;
      end
      send_random_command;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_odd_tags;
    test_fractions;
    test_saturation;
    wait_for_results;
    test_output_backpressure;
    test_random_commands;
    wait_for_results;
    repeat (80) @(posedge clk);
    while (due_results.size() != 0) begin
      report_mismatch("result never arrived", 32'(due_results[0].target),
                      due_results[0].value);
      void'(due_results.pop_front());
    end
    $display("sent %0d bytes, checked %0d results (%0d stop, %0d saturated), %0d aborts",
             bytes_sent, results_checked, stops_due, overflows_due, aborts_seen);
    $display("%0d mismatches in %0d cycles", errors, cycle_count);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tdcp_pkg.sv
rtl/core/tdcp_lexer.sv
rtl/core/tdcp_divider.sv
rtl/core/tagged_decimal_command_parser.sv
sim/tb_tagged_decimal_command_parser.sv
